// ===== rtl/lpsc_pkg.sv =====
// lpsc_pkg: shared types and constants for the length-prefix to start-code converter
// no dependencies; used by lpsc_front, lpsc_fifo, lpsc_back and the top level
package lpsc_pkg;

    localparam int SizeBitsDefault   = 24;
    localparam int QueueDepthDefault = 4;

    localparam int ByteW       = 8;
    localparam int UnitSizeW   = 24;
    localparam int PrefixCfgW  = 3;
    localparam int LenW        = 32;
    localparam int StartCodeN  = 4;
    localparam int StartIdxW   = 2;

    localparam logic [PrefixCfgW-1:0] PrefixReset = 3'd4;
    localparam logic [PrefixCfgW-1:0] PrefixMax   = 3'd4;

    localparam logic [ByteW-1:0] START_CODE [StartCodeN] = '{8'h00, 8'h00, 8'h00, 8'h01};

    // one queued command: a whole start code or one payload byte
    typedef struct packed {
        logic             is_sc;
        logic             nal_end;
        logic [ByteW-1:0] data;
    } t_cmd;

endpackage

// ===== rtl/lpsc_front.sv =====
// lpsc_front: prefix parser, classifies each accepted byte and queues a command for a valid
// prefix's last byte or a payload byte; depends on lpsc_pkg
module lpsc_front #(
    parameter int SIZE_BITS = lpsc_pkg::SizeBitsDefault
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_accept,
    input  logic [lpsc_pkg::ByteW-1:0]            i_data_byte,
    input  logic                                  i_first_of_unit,
    input  logic [lpsc_pkg::UnitSizeW-1:0]        i_unit_size,
    input  logic                                  i_cfg_we,
    input  logic [lpsc_pkg::PrefixCfgW-1:0]       i_cfg_prefix_bytes,
    output logic                                  o_push,
    output lpsc_pkg::t_cmd                        o_cmd
);

    typedef enum logic [1:0] {
        MODE_STOPPED = 2'd0,
        MODE_PREFIX  = 2'd1,
        MODE_PAYLOAD = 2'd2
    } t_mode;

    localparam int LenW = lpsc_pkg::LenW;
    localparam int PfxW = lpsc_pkg::PrefixCfgW;

    t_mode                 r_mode, n_mode;
    logic [SIZE_BITS-1:0]  r_left, n_left;
    logic [LenW-1:0]       r_acc, n_acc;
    logic [PfxW-1:0]       r_seen, n_seen;
    logic [LenW-1:0]       r_rem, n_rem;
    logic [PfxW-1:0]       r_prefix_bytes;

    logic [SIZE_BITS-1:0]  w_size_in;
    logic [PfxW-1:0]       w_pw;

    // unit size masked to SIZE_BITS
    generate
        if (SIZE_BITS > lpsc_pkg::UnitSizeW) begin : g_size_wide
            assign w_size_in = {{(SIZE_BITS - lpsc_pkg::UnitSizeW){1'b0}}, i_unit_size};
        end else if (SIZE_BITS == lpsc_pkg::UnitSizeW) begin : g_size_eq
            assign w_size_in = i_unit_size;
        end else begin : g_size_narrow
            assign w_size_in = i_unit_size[SIZE_BITS-1:0];
        end
    endgenerate

    assign w_pw = (r_prefix_bytes > lpsc_pkg::PrefixMax) ? lpsc_pkg::PrefixMax
                                                          : r_prefix_bytes;

    always_comb begin
        t_mode                e_mode;
        logic [SIZE_BITS-1:0] e_left;
        logic [LenW-1:0]      e_acc;
        logic [PfxW-1:0]      e_seen;
        logic [LenW-1:0]      e_rem;
        logic [LenW-1:0]      w_acc;
        logic [PfxW-1:0]      w_seen;
        logic [LenW-1:0]      w_rem;
        logic [LenW-1:0]      w_left32;

        n_mode = r_mode;
        n_left = r_left;
        n_acc  = r_acc;
        n_seen = r_seen;
        n_rem  = r_rem;
        o_push = 1'b0;
        o_cmd  = '0;

        if (i_first_of_unit) begin
            e_mode = MODE_PREFIX;
            e_left = w_size_in;
            e_acc  = '0;
            e_seen = '0;
            e_rem  = '0;
        end else begin
            e_mode = r_mode;
            e_left = r_left;
            e_acc  = r_acc;
            e_seen = r_seen;
            e_rem  = r_rem;
        end

        w_acc    = (e_seen == '0) ? {{(LenW - lpsc_pkg::ByteW){1'b0}}, i_data_byte}
                                  : {e_acc[LenW-lpsc_pkg::ByteW-1:0], i_data_byte};
        w_seen   = e_seen + PfxW'(1);
        w_rem    = (e_rem != '0) ? (e_rem - LenW'(1)) : e_rem;
        w_left32 = LenW'(e_left);

        if (i_accept) begin
            n_mode = e_mode;
            n_left = e_left;
            n_acc  = e_acc;
            n_seen = e_seen;
            n_rem  = e_rem;
            if (e_left == '0) begin
                // byte past the end of the unit
                n_mode = MODE_STOPPED;
            end else begin
                n_left = e_left - SIZE_BITS'(1);
                case (e_mode)
                    MODE_PREFIX: begin
                        if (e_seen == '0 &&
                            (w_pw == '0 || e_left < SIZE_BITS'(w_pw))) begin
                            // short tail
                            n_mode = MODE_STOPPED;
                        end else if (w_seen < w_pw) begin
                            n_acc  = w_acc;
                            n_seen = w_seen;
                        end else begin
                            n_seen = '0;
                            n_acc  = w_acc;
                            // fit test: length <= bytes left after this one
                            if (w_acc == '0 || w_acc >= w_left32) begin
                                n_mode = MODE_STOPPED;
                            end else begin
                                n_rem        = w_acc;
                                n_acc        = '0;
                                n_mode       = MODE_PAYLOAD;
                                o_push       = 1'b1;
                                o_cmd.is_sc  = 1'b1;
                            end
                        end
                    end
                    MODE_PAYLOAD: begin
                        n_rem = w_rem;
                        if (w_rem == '0) begin
                            n_mode = MODE_PREFIX;
                            n_seen = '0;
                            n_acc  = '0;
                        end
                        o_push        = 1'b1;
                        o_cmd.data    = i_data_byte;
                        o_cmd.nal_end = (w_rem == '0);
                    end
                    default: begin
                        n_mode = MODE_STOPPED;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_STOPPED;
            r_left         <= '0;
            r_acc          <= '0;
            r_seen         <= '0;
            r_rem          <= '0;
            r_prefix_bytes <= lpsc_pkg::PrefixReset;
        end else begin
            r_mode <= n_mode;
            r_left <= n_left;
            r_acc  <= n_acc;
            r_seen <= n_seen;
            r_rem  <= n_rem;
            if (i_cfg_we) begin
                r_prefix_bytes <= i_cfg_prefix_bytes;
            end
        end
    end

endmodule

// ===== rtl/lpsc_fifo.sv =====
// lpsc_fifo: small command queue between parser and output sequencer
// depends on lpsc_pkg
module lpsc_fifo #(
    parameter int DEPTH = lpsc_pkg::QueueDepthDefault
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lpsc_pkg::t_cmd  i_cmd,
    input  logic            i_pop,
    output lpsc_pkg::t_cmd  o_cmd,
    output logic            o_empty,
    output logic            o_full
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    lpsc_pkg::t_cmd   r_mem [DEPTH];
    logic [PtrW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0]  r_count;

    logic w_push, w_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CntW'(DEPTH));
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + PtrW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + PtrW'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + CntW'(1);
                2'b01:   r_count <= r_count - CntW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/lpsc_back.sv =====
// lpsc_back: output sequencer, expands queued commands into output bytes
// depends on lpsc_pkg
module lpsc_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lpsc_pkg::t_cmd              i_cmd,
    input  logic                        i_empty,
    output logic                        o_pop,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output logic [lpsc_pkg::ByteW-1:0]  o_out_byte,
    output logic                        o_is_start_code,
    output logic                        o_nal_end,
    output logic                        o_last_of_run
);

    localparam int IdxW = lpsc_pkg::StartIdxW;

    logic [IdxW-1:0]               r_sc_idx;
    logic                          r_out_valid;
    logic [lpsc_pkg::ByteW-1:0]    r_out_byte;
    logic                          r_is_start_code;
    logic                          r_nal_end;
    logic                          r_last_of_run;

    logic w_load, w_sc_last;

    assign w_load    = !r_out_valid || !i_out_stall;
    assign w_sc_last = (r_sc_idx == IdxW'(lpsc_pkg::StartCodeN - 1));
    assign o_pop     = w_load && !i_empty && (!i_cmd.is_sc || w_sc_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc_idx    <= '0;
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= !i_empty;
            if (!i_empty && i_cmd.is_sc) begin
                r_sc_idx <= w_sc_last ? '0 : r_sc_idx + IdxW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && !i_empty) begin
            if (i_cmd.is_sc) begin
                r_out_byte      <= lpsc_pkg::START_CODE[r_sc_idx];
                r_is_start_code <= 1'b1;
                r_nal_end       <= 1'b0;
                r_last_of_run   <= w_sc_last;
            end else begin
                r_out_byte      <= i_cmd.data;
                r_is_start_code <= 1'b0;
                r_nal_end       <= i_cmd.nal_end;
                r_last_of_run   <= 1'b1;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_byte      = r_out_byte;
    assign o_is_start_code = r_is_start_code;
    assign o_nal_end       = r_nal_end;
    assign o_last_of_run   = r_last_of_run;

endmodule

// ===== rtl/length_prefix_to_start_code_top.sv =====
// length_prefix_to_start_code_top: length-prefixed NAL units to start-code stream
// depends on lpsc_pkg, lpsc_front, lpsc_fifo, lpsc_back

// Converts access units of big-endian length-prefixed NAL units into a start-code
// stream. The front parser takes one input transfer per cycle, back to back, while the
// command queue (QUEUE_DEPTH entries) has room; once the queue is full every input
// stalls, whether or not that byte would give a result. A valid prefix's last byte
// queues a start code, which the output sequencer sends as four transfers; each
// payload byte gives one output transfer. The front queues an accepted byte's command,
// and the sequencer fills the registered output from the queue head. A zero
// or overrunning length, a short tail, or a byte past unit_size stops the unit until the
// next first_of_unit. The output is registered and holds while the downstream side
// stalls; the sequencer pops the queue only when that register is free, so the front
// keeps filling the queue until it is full. Short prefixes with short payloads give
// more output than input, and the queue absorbs that until it fills.
// prefix_bytes is written through the config channel (always ready), values above
// four act as four and zero drops every unit.
module length_prefix_to_start_code_top #(
    parameter int SIZE_BITS   = lpsc_pkg::SizeBitsDefault,
    parameter int QUEUE_DEPTH = lpsc_pkg::QueueDepthDefault
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input byte channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [lpsc_pkg::ByteW-1:0]        i_data_byte,
    input  logic                              i_first_of_unit,
    input  logic [lpsc_pkg::UnitSizeW-1:0]    i_unit_size,
    // output byte channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [lpsc_pkg::ByteW-1:0]        o_out_byte,
    output logic                              o_is_start_code,
    output logic                              o_nal_end,
    output logic                              o_last_of_run,
    // config write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lpsc_pkg::PrefixCfgW-1:0]   i_cfg_prefix_bytes
);

    logic            w_accept;
    logic            w_push;
    lpsc_pkg::t_cmd  w_push_cmd;
    lpsc_pkg::t_cmd  w_head_cmd;
    logic            w_empty, w_full, w_pop;

    // input transfer only while the queue has room
    assign o_in_stall  = w_full;
    assign w_accept    = i_in_valid && !w_full;
    assign o_cfg_ready = 1'b1;

    lpsc_front #(
        .SIZE_BITS (SIZE_BITS)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (w_accept),
        .i_data_byte        (i_data_byte),
        .i_first_of_unit    (i_first_of_unit),
        .i_unit_size        (i_unit_size),
        .i_cfg_we           (i_cfg_valid),
        .i_cfg_prefix_bytes (i_cfg_prefix_bytes),
        .o_push             (w_push),
        .o_cmd              (w_push_cmd)
    );

    // decouples parsing from start-code expansion
    lpsc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    lpsc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_head_cmd),
        .i_empty         (w_empty),
        .o_pop           (w_pop),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_out_byte      (o_out_byte),
        .o_is_start_code (o_is_start_code),
        .o_nal_end       (o_nal_end),
        .o_last_of_run   (o_last_of_run)
    );

endmodule

// ===== sim/length_prefix_to_start_code_top_tb.sv =====
`timescale 1ns / 1ps
// length_prefix_to_start_code_top_tb: self-checking bench for the length-prefix converter
// depends on lpsc_pkg and length_prefix_to_start_code_top; predicts the start-code stream
// per accepted byte and checks every output transfer in order
module length_prefix_to_start_code_top_tb;

    localparam int BYTE_W = lpsc_pkg::ByteW;
    localparam int SIZE_W = lpsc_pkg::UnitSizeW;
    localparam int PFX_W  = lpsc_pkg::PrefixCfgW;
    localparam int LEN_W  = lpsc_pkg::LenW;
    localparam int SC_N   = lpsc_pkg::StartCodeN;
    localparam logic [PFX_W-1:0] PFX_RESET = lpsc_pkg::PrefixReset;
    localparam logic [PFX_W-1:0] PFX_MAX   = lpsc_pkg::PrefixMax;

    localparam int unsigned CLK_HALF     = 10;
    localparam int unsigned RESET_CYCLES = 11;
    // no-result bytes may still sit in the front parser once the stream has drained
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned DRAIN_LIMIT   = 5000;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned REPORT_MAX    = 10;
    localparam int unsigned PHASE_BYTES   = 16;

    typedef enum logic [1:0] {
        PARSE_STOPPED = 2'd0,
        PARSE_PREFIX  = 2'd1,
        PARSE_PAYLOAD = 2'd2
    } t_parse_mode;

    // shapes of access unit the random part builds
    typedef enum int unsigned {
        UNIT_CLEAN,
        UNIT_SHORT_SIZE,
        UNIT_SHORT_TAIL,
        UNIT_ZERO_LEN,
        UNIT_WILD_LEN,
        UNIT_PAST_END,
        UNIT_NOISE
    } t_unit_kind;

    // one output byte as the sink sees it
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              is_sc;
        logic              nal_end;
        logic              last;
    } t_result;

    logic                  i_clk              = 1'b0;
    logic                  i_rst_n            = 1'b0;
    logic                  i_in_valid         = 1'b0;
    logic                  o_in_stall;
    logic [BYTE_W-1:0]     i_data_byte        = '0;
    logic                  i_first_of_unit    = 1'b0;
    logic [SIZE_W-1:0]     i_unit_size        = '0;
    logic                  o_out_valid;
    logic                  i_out_stall        = 1'b0;
    logic [BYTE_W-1:0]     o_out_byte;
    logic                  o_is_start_code;
    logic                  o_nal_end;
    logic                  o_last_of_run;
    logic                  i_cfg_valid        = 1'b0;
    logic                  o_cfg_ready;
    logic [PFX_W-1:0]      i_cfg_prefix_bytes = PFX_RESET;

    length_prefix_to_start_code_top dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_data_byte        (i_data_byte),
        .i_first_of_unit    (i_first_of_unit),
        .i_unit_size        (i_unit_size),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_out_byte         (o_out_byte),
        .o_is_start_code    (o_is_start_code),
        .o_nal_end          (o_nal_end),
        .o_last_of_run      (o_last_of_run),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_prefix_bytes (i_cfg_prefix_bytes)
    );

    // ------------------------------------------------------------------
    // predictor state: a private copy of the parser and the prefix register
    // ------------------------------------------------------------------
    logic [PFX_W-1:0]      prefix_cfg   = PFX_RESET;
    t_parse_mode           parse_mode   = PARSE_STOPPED;
    logic [31:0]           unit_len     = '0;
    logic [31:0]           byte_pos     = '0;
    logic [LEN_W-1:0]      len_acc      = '0;
    logic [2:0]            prefix_seen  = '0;
    logic [LEN_W-1:0]      payload_left = '0;

    // output bytes predicted but not yet seen, oldest first
    t_result stream_due[$];

    int unsigned fail_count     = 0;
    int unsigned bytes_sent     = 0;
    int unsigned units_sent     = 0;
    int unsigned results_seen   = 0;
    int unsigned cycle_count    = 0;
    int unsigned sink_wait_left = 0;
    bit          no_idle        = 1'b0;

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // per-transfer wait for either side; about half the draws give no wait at all
    function automatic int unsigned draw_wait();
        if (no_idle)
            return 0;
        return ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(0, 8);
    endfunction

    // append one predicted output byte
    task automatic expect_result(input t_result r);
        stream_due.insert(stream_due.size(), r);
    endtask

    // advance the parser copy by one accepted byte and queue the bytes it emits
    task automatic predict_annexb(input logic [BYTE_W-1:0] b, input logic first,
                                  input logic [SIZE_W-1:0] size);
        logic [2:0]  width;
        logic [31:0] pos;
        width = (prefix_cfg > PFX_MAX) ? PFX_MAX : prefix_cfg;
        if (first) begin
            unit_len     = 32'(size);
            byte_pos     = '0;
            parse_mode   = PARSE_PREFIX;
            len_acc      = '0;
            prefix_seen  = '0;
            payload_left = '0;
        end
        pos = byte_pos;
        // byte at or past the unit size: dropped, unit closed
        if (pos >= unit_len) begin
            parse_mode = PARSE_STOPPED;
            return;
        end
        byte_pos = pos + 32'd1;
        case (parse_mode)
            PARSE_PREFIX: begin
                if (prefix_seen == 3'd0) begin
                    // width zero or a tail too short for a whole prefix
                    if (width == 3'd0 || (unit_len - pos) < 32'(width)) begin
                        parse_mode = PARSE_STOPPED;
                        return;
                    end
                    len_acc = '0;
                end
                len_acc     = {len_acc[LEN_W-9:0], b};
                prefix_seen = prefix_seen + 3'd1;
                if (prefix_seen < width)
                    return;
                prefix_seen = '0;
                // zero length or a length running past the unit end
                if (len_acc == '0 || len_acc > (unit_len - byte_pos)) begin
                    parse_mode = PARSE_STOPPED;
                    return;
                end
                payload_left = len_acc;
                len_acc      = '0;
                parse_mode   = PARSE_PAYLOAD;
                for (int i = 0; i < SC_N; i++)
                    expect_result(t_result'{lpsc_pkg::START_CODE[i], 1'b1, 1'b0,
                                            i == SC_N - 1});
            end
            PARSE_PAYLOAD: begin
                if (payload_left != '0)
                    payload_left = payload_left - 32'd1;
                if (payload_left == '0) begin
                    parse_mode  = PARSE_PREFIX;
                    prefix_seen = '0;
                    len_acc     = '0;
                end
                expect_result(t_result'{b, 1'b0, payload_left == '0, 1'b1});
            end
            default: parse_mode = PARSE_STOPPED;
        endcase
    endtask

    // one input transfer: optional idle gap, then hold the byte until the dut takes it
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic first,
                             input logic [SIZE_W-1:0] size);
        int unsigned gap;
        gap = draw_wait();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_data_byte     <= b;
        i_first_of_unit <= first;
        i_unit_size     <= size;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_annexb(b, first, size);
        bytes_sent++;
        if (first)
            units_sent++;
    endtask

    // register write only once the output has drained and the front has settled
    task automatic set_prefix_width(input logic [PFX_W-1:0] width);
        i_in_valid <= 1'b0;
        while (stream_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid        <= 1'b1;
        i_cfg_prefix_bytes <= width;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        prefix_cfg  = width;
    endtask

    // build one access unit for the current prefix width, broken in the way kind asks
    task automatic send_unit(input t_unit_kind kind);
        logic [BYTE_W-1:0]    unit_bytes[$];
        logic [SIZE_W-1:0]    size;
        logic [31:0]          len_field;
        logic [2:0]           width;
        int unsigned          nals;
        int unsigned          len;
        int unsigned          extra;
        width = (prefix_cfg == '0 || prefix_cfg > PFX_MAX) ? PFX_MAX : prefix_cfg;
        len   = 1;
        if (kind == UNIT_NOISE) begin
            // raw bytes, random unit boundaries and sizes
            repeat ($urandom_range(3, 10))
                send_byte(BYTE_W'($urandom), $urandom_range(0, 3) == 0,
                          SIZE_W'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 40)
                                                                : $urandom));
            return;
        end
        nals = $urandom_range(1, 3);
        for (int n = 0; n < nals; n++) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 5);
            len_field = len;
            if (n == nals - 1 && kind == UNIT_ZERO_LEN)
                len_field = '0;
            if (n == nals - 1 && kind == UNIT_WILD_LEN)
                len_field = $urandom;
            for (int i = int'(width); i > 0; i--)
                unit_bytes.insert(unit_bytes.size(), len_field[8*(i-1) +: 8]);
            repeat (len) unit_bytes.insert(unit_bytes.size(), BYTE_W'($urandom));
        end
        size = SIZE_W'(unit_bytes.size());
        case (kind)
            // declared size cuts into the last payload so its length overruns
            UNIT_SHORT_SIZE: size = size - SIZE_W'($urandom_range(1, (len < 3) ? len : 3));
            // a few trailing bytes, not enough for another prefix
            UNIT_SHORT_TAIL: begin
                extra = (width > 3'd1) ? $urandom_range(1, 32'(width) - 32'd1) : 0;
                repeat (extra) unit_bytes.insert(unit_bytes.size(), BYTE_W'($urandom));
                size = SIZE_W'(unit_bytes.size());
            end
            // bytes sent past the declared size
            UNIT_PAST_END: repeat ($urandom_range(1, 3))
                unit_bytes.insert(unit_bytes.size(), BYTE_W'($urandom));
            default: ;
        endcase
        // unit_size is only read on the first byte, so the rest carry junk there
        foreach (unit_bytes[i])
            send_byte(unit_bytes[i], i == 0, (i == 0) ? size : SIZE_W'($urandom));
    endtask

    // one phase of random units at a fixed prefix width
    task automatic run_random_phase(input logic [PFX_W-1:0] width,
                                    input int unsigned budget);
        int unsigned start;
        int unsigned pick;
        set_prefix_width(width);
        start = bytes_sent;
        while (bytes_sent - start < budget) begin
            pick = $urandom_range(0, 19);
            case (pick)
                12:      send_unit(UNIT_SHORT_SIZE);
                13:      send_unit(UNIT_SHORT_TAIL);
                14:      send_unit(UNIT_ZERO_LEN);
                15:      send_unit(UNIT_WILD_LEN);
                16:      send_unit(UNIT_PAST_END);
                17:      send_unit(UNIT_NOISE);
                default: send_unit(UNIT_CLEAN);
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // the parser starts stopped: nothing comes out until a unit is opened
    task automatic test_bytes_before_first_unit();
        send_byte(8'h5A, 1'b0, 24'd7);
    endtask

    // four-byte prefixes: a clean nal with a short tail and a byte past the end,
    // then a zero length and an overrunning length
    task automatic test_clean_and_broken_units();
        logic [BYTE_W-1:0] clean_unit[$];
        clean_unit = '{8'h00, 8'h00, 8'h00, 8'h03, 8'hAA, 8'hBB, 8'hCC, 8'hEE, 8'h01, 8'h55};
        set_prefix_width(3'd4);
        foreach (clean_unit[i])
            send_byte(clean_unit[i], i == 0, 24'd9);
        for (int i = 0; i < 4; i++)
            send_byte(8'h00, i == 0, 24'd4);
        for (int i = 0; i < 4; i++)
            send_byte(8'hFF, i == 0, 24'd4);
    endtask

    // empty unit, then the largest unit size with a length that just fits
    task automatic test_unit_size_extremes();
        logic [BYTE_W-1:0] big_unit[$];
        big_unit = '{8'h00, 8'hFF, 8'hFF, 8'hFB, 8'h9C};
        send_byte(8'hC3, 1'b1, 24'd0);
        foreach (big_unit[i])
            send_byte(big_unit[i], i == 0, 24'hFF_FFFF);
    endtask

    // register values 1, 3 and 4, zero (all dropped), and 5 to 7 above four
    task automatic test_prefix_width_sweep();
        run_random_phase(3'd1, PHASE_BYTES);
        run_random_phase(3'd3, PHASE_BYTES);
        run_random_phase(3'd4, PHASE_BYTES);
        run_random_phase(3'd0, 12);
        run_random_phase(3'd5, PHASE_BYTES);
        run_random_phase(3'd7, PHASE_BYTES);
        run_random_phase(3'd6, PHASE_BYTES);
    endtask

    // full rate on both sides so the command queue fills behind start codes
    task automatic test_back_to_back();
        no_idle = 1'b1;
        run_random_phase(3'd2, PHASE_BYTES);
        no_idle = 1'b0;
        run_random_phase(3'd2, PHASE_BYTES);
    endtask

    // ------------------------------------------------------------------
    // output side: random stall per transfer, in-order compare
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : sink
        t_result     got;
        t_result     want;
        int unsigned hold;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = t_result'{o_out_byte, o_is_start_code, o_nal_end, o_last_of_run};
            results_seen++;
            if (stream_due.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("unexpected output byte %02h sc %b end %b last %b",
                             got.data, got.is_sc, got.nal_end, got.last);
            end else begin
                want = stream_due.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("mismatch %0d: exp %02h/%b/%b/%b got %02h/%b/%b/%b",
                                 results_seen,
                                 want.data, want.is_sc, want.nal_end, want.last,
                                 got.data, got.is_sc, got.nal_end, got.last);
                end
            end
            // draw a fresh random stall after each transfer, which may be none
            hold = draw_wait();
            i_out_stall    <= (hold != 0);
            sink_wait_left <= hold;
        end else if (sink_wait_left != 0) begin
            sink_wait_left <= sink_wait_left - 1;
            if (sink_wait_left == 1)
                i_out_stall <= 1'b0;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d output bytes outstanding",
                     cycle_count, stream_due.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin : main
        int unsigned drain;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_bytes_before_first_unit();
        test_clean_and_broken_units();
        test_unit_size_extremes();
        test_prefix_width_sweep();
        test_back_to_back();

        // let the stream drain, then leave room for any late byte
        i_in_valid <= 1'b0;
        drain = 0;
        while (stream_due.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (stream_due.size() != 0) begin
            fail_count++;
            $display("%0d expected output bytes never arrived", stream_due.size());
        end

        $display("%0d input bytes in %0d units, %0d output bytes compared, %0d failures",
                 bytes_sent, units_sent, results_seen, fail_count);
        $display("prefix widths 0 to 7 used; random gaps on both sides plus a gap-free stretch");
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/lpsc_pkg.sv
rtl/lpsc_front.sv
rtl/lpsc_fifo.sv
rtl/lpsc_back.sv
rtl/length_prefix_to_start_code_top.sv
sim/length_prefix_to_start_code_top_tb.sv
